/* sv/lcadc_pkg.sv */
// Shared widths, register indexes and defaults for the load cell reader.
`default_nettype none
package lcadc_pkg;
  localparam int ADC_BITS_DEF     = 24;
  localparam int MAX_READINGS_DEF = 64;

  localparam int RAW_W    = 24;
  localparam int SCALE_W  = 24;
  localparam int SAMP_W   = 7;
  localparam int TMO_W    = 20;
  localparam int SUM_W    = 30;
  localparam int BIT_CW   = 5;
  localparam int GRAMS_W  = 25;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 24;
  localparam int FRAC_W   = 24;

  localparam logic [IDX_W-1:0] REG_TARE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SCALE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_MARGIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SAMPLES = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIMEOUT = 3'd4;

  localparam logic [RAW_W-1:0]   TARE_RST    = 24'd9037565;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 24'd24666;
  localparam logic [RAW_W-1:0]   MARGIN_RST  = 24'd200;
  localparam logic [SAMP_W-1:0]  SAMPLES_RST = 7'd30;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST = 20'd200000;

  localparam logic [RAW_W-1:0] WEIGHT_LIMIT = 24'hFFFFFF;
endpackage
`default_nettype wire

/* sv/lcadc_if.sv */
// Channel interfaces: tick input, weight result output, register writes.
`default_nettype none
interface lcadc_tick_if;
  logic valid;
  logic ready;
  logic dt_level;
  modport source (output valid, output dt_level, input ready);
  modport sink (input valid, input dt_level, output ready);
endinterface

interface lcadc_res_if import lcadc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      sck_level;
  logic                      weight_valid;
  logic signed [GRAMS_W-1:0] weight_grams;
  logic                      reading_timeout;
  modport source (output valid, output sck_level, output weight_valid,
                  output weight_grams, output reading_timeout, input ready);
  modport sink (input valid, input sck_level, input weight_valid,
                input weight_grams, input reading_timeout, output ready);
endinterface

interface lcadc_cfg_if import lcadc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/load_cell_adc_read_average_scale.sv */
// Load cell converter reader: bit clocking, averaging, tare and scaling.
// A plain tick's result goes to a pending register, then to the output register; a tick
//   that finishes a weight group runs the bit-serial divider, then the diff, multiply and
//   finish states. A new tick is taken only while idle with no result pending.
// One result may wait in the output register while the next tick is processed.
// Reset (rst, synchronous) restores register defaults and clears all control state.
`default_nettype none
module load_cell_adc_read_average_scale import lcadc_pkg::*; #(
  parameter int ADC_BITS     = ADC_BITS_DEF,
  parameter int MAX_READINGS = MAX_READINGS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  lcadc_tick_if.sink  dt_ch,
  lcadc_res_if.source res_ch,
  lcadc_cfg_if.sink   cfg
);
  localparam int CNT_W = $clog2(MAX_READINGS + 1);
  localparam logic [SAMP_W-1:0] MAX_N   = SAMP_W'(MAX_READINGS);
  localparam logic [BIT_CW-1:0] LAST_BIT = BIT_CW'(ADC_BITS);
  localparam logic [BIT_CW-1:0] DIV_LAST = BIT_CW'(SUM_W - 1);

  localparam logic [2:0] PH_WAIT  = 3'd0;
  localparam logic [2:0] PH_HIGH  = 3'd1;
  localparam logic [2:0] PH_LOW   = 3'd2;
  localparam logic [2:0] PH_XHIGH = 3'd3;
  localparam logic [2:0] PH_XLOW  = 3'd4;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [RAW_W-1:0]   tare;
  logic [SCALE_W-1:0] scale;
  logic [RAW_W-1:0]   margin;
  logic [SAMP_W-1:0]  samples;
  logic [TMO_W-1:0]   timeout;

  logic [2:0]          phase, phase_next;
  logic [BIT_CW-1:0]   bit_count, bit_count_next;
  logic [ADC_BITS-1:0] shift_word, shift_word_next;
  logic [TMO_W-1:0]    wait_count, wait_count_next;
  logic [CNT_W-1:0]    reading_count;
  logic [SUM_W-1:0]    reading_sum;

  logic [2:0]          st;
  logic [BIT_CW-1:0]   div_cnt;
  logic [CNT_W-1:0]    div_n;
  logic [CNT_W-1:0]    rem;
  logic [SUM_W-1:0]    quo;
  logic [SUM_W-1:0]    mag;
  logic                neg;
  logic                small_diff;
  logic [SUM_W+SCALE_W-1:0] prod;

  logic                      pend;
  logic                      res_sck;
  logic                      res_wv;
  logic signed [GRAMS_W-1:0] res_grams;
  logic                      res_tmo;

  logic                      out_valid;
  logic                      out_sck;
  logic                      out_wv;
  logic signed [GRAMS_W-1:0] out_grams;
  logic                      out_tmo;

  logic             tick_fire;
  logic             sck;
  logic             tmo;
  logic             done;
  logic [SUM_W-1:0] reading;
  logic [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0] cnt_acc;
  logic [CNT_W-1:0] n_eff;
  logic             due;

  logic [CNT_W:0]       div_t;
  logic                 div_ge;
  logic signed [SUM_W:0] diff;
  logic [SUM_W-1:0]     q_full;
  logic [RAW_W-1:0]     q_clamp;
  logic signed [GRAMS_W-1:0] q_signed;

  assign dt_ch.ready = (st == ST_IDLE) && !pend;
  assign tick_fire   = dt_ch.valid && dt_ch.ready;
  assign cfg.ready   = 1'b1;

  assign res_ch.valid           = out_valid;
  assign res_ch.sck_level       = out_sck;
  assign res_ch.weight_valid    = out_wv;
  assign res_ch.weight_grams    = out_grams;
  assign res_ch.reading_timeout = out_tmo;

  always_comb begin
    priority if (samples == '0) begin
      n_eff = CNT_W'(1);
    end else if (samples > MAX_N) begin
      n_eff = CNT_W'(MAX_READINGS);
    end else begin
      n_eff = samples[CNT_W-1:0];
    end
  end

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_word_next = shift_word;
    wait_count_next = wait_count;
    sck             = 1'b0;
    tmo             = 1'b0;
    done            = 1'b0;
    reading         = '0;
    unique case (phase)
      PH_HIGH: begin
        sck        = 1'b1;
        phase_next = PH_LOW;
      end
      PH_LOW: begin
        shift_word_next = {shift_word[ADC_BITS-2:0], dt_ch.dt_level};
        bit_count_next  = bit_count + BIT_CW'(1);
        phase_next      = (bit_count_next >= LAST_BIT) ? PH_XHIGH : PH_HIGH;
      end
      PH_XHIGH: begin
        sck        = 1'b1;
        phase_next = PH_XLOW;
      end
      PH_XLOW: begin
        done            = 1'b1;
        reading         = SUM_W'({~shift_word[ADC_BITS-1], shift_word[ADC_BITS-2:0]});
        phase_next      = PH_WAIT;
        wait_count_next = '0;
      end
      default: begin
        if (!dt_ch.dt_level) begin
          phase_next      = PH_HIGH;
          bit_count_next  = '0;
          shift_word_next = '0;
          wait_count_next = '0;
        end else if (wait_count >= timeout) begin
          tmo             = 1'b1;
          done            = 1'b1;
          wait_count_next = '0;
        end else begin
          wait_count_next = wait_count + TMO_W'(1);
        end
      end
    endcase
    sum_acc = reading_sum + reading;
    cnt_acc = reading_count + CNT_W'(1);
    due     = done && (cnt_acc >= n_eff);
  end

  always_comb begin
    div_t    = {rem, quo[SUM_W-1]};
    div_ge   = div_t >= {1'b0, div_n};
    diff     = $signed({1'b0, quo}) - $signed({{(SUM_W+1-RAW_W){1'b0}}, tare});
    q_full   = prod[SUM_W+SCALE_W-1:FRAC_W];
    q_clamp  = (q_full > SUM_W'(WEIGHT_LIMIT)) ? WEIGHT_LIMIT : q_full[RAW_W-1:0];
    q_signed = neg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tare          <= TARE_RST;
      scale         <= SCALE_RST;
      margin        <= MARGIN_RST;
      samples       <= SAMPLES_RST;
      timeout       <= TIMEOUT_RST;
      phase         <= PH_WAIT;
      bit_count     <= '0;
      shift_word    <= '0;
      wait_count    <= '0;
      reading_count <= '0;
      reading_sum   <= '0;
      st            <= ST_IDLE;
      div_cnt       <= '0;
      pend          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_TARE:    tare    <= cfg.data[RAW_W-1:0];
          REG_SCALE:   scale   <= cfg.data[SCALE_W-1:0];
          REG_MARGIN:  margin  <= cfg.data[RAW_W-1:0];
          REG_SAMPLES: samples <= cfg.data[SAMP_W-1:0];
          REG_TIMEOUT: timeout <= cfg.data[TMO_W-1:0];
          default: ;
        endcase
      end

      if (pend && (!out_valid || res_ch.ready)) begin
        out_valid <= 1'b1;
        out_sck   <= res_sck;
        out_wv    <= res_wv;
        out_grams <= res_grams;
        out_tmo   <= res_tmo;
        pend      <= 1'b0;
      end else if (res_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (st)
        ST_DIV: begin
          quo <= {quo[SUM_W-2:0], div_ge};
          rem <= div_ge ? CNT_W'(div_t - {1'b0, div_n}) : div_t[CNT_W-1:0];
          if (div_cnt == '0) begin
            st <= ST_DIFF;
          end else begin
            div_cnt <= div_cnt - BIT_CW'(1);
          end
        end
        ST_DIFF: begin
          neg        <= diff[SUM_W];
          mag        <= diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
          small_diff <= (diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0])
                        < SUM_W'(margin);
          st         <= ST_MUL;
        end
        ST_MUL: begin
          prod <= (SUM_W+SCALE_W)'(mag) * (SUM_W+SCALE_W)'(scale);
          st   <= ST_FIN;
        end
        ST_FIN: begin
          pend      <= 1'b1;
          res_sck   <= 1'b0;
          res_wv    <= 1'b1;
          res_grams <= small_diff ? '0 : q_signed;
          st        <= ST_IDLE;
        end
        default: begin
          if (tick_fire) begin
            phase      <= phase_next;
            bit_count  <= bit_count_next;
            shift_word <= shift_word_next;
            wait_count <= wait_count_next;
            res_sck    <= sck;
            res_wv     <= 1'b0;
            res_grams  <= '0;
            res_tmo    <= tmo;
            if (due) begin
              quo           <= sum_acc;
              rem           <= '0;
              div_n         <= n_eff;
              div_cnt       <= DIV_LAST;
              reading_sum   <= '0;
              reading_count <= '0;
              st            <= ST_DIV;
            end else begin
              pend <= 1'b1;
              if (done) begin
                reading_sum   <= sum_acc;
                reading_count <= cnt_acc;
              end
            end
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/lcadc_chk.sv */
// Port-level checker for the load cell reader, bound to the top level.
`default_nettype none
module lcadc_chk import lcadc_pkg::*; (
  input wire                      clk,
  input wire                      rst,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire                      sck_level,
  input wire                      weight_valid,
  input wire signed [GRAMS_W-1:0] weight_grams,
  input wire                      reading_timeout
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight_grams) && $stable(sck_level))
    else $error("result changed while stalled");

  a_rst_clear: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !weight_valid |-> weight_grams == '0)
    else $error("nonzero grams without a weight");

  a_wv_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && weight_valid |-> !sck_level)
    else $error("weight given on a clock high tick");

  a_tmo_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && reading_timeout |-> !sck_level)
    else $error("timeout on a clock high tick");
endmodule

bind load_cell_adc_read_average_scale lcadc_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (res_ch.valid),
  .out_ready       (res_ch.ready),
  .sck_level       (res_ch.sck_level),
  .weight_valid    (res_ch.weight_valid),
  .weight_grams    (res_ch.weight_grams),
  .reading_timeout (res_ch.reading_timeout)
);
`default_nettype wire
